>>> rtl/pbbn_pkg.sv
// Shared types and constants of the point bounding box normaliser.
package pbbn_pkg;

  localparam int COORD_W    = 32;
  localparam int AXES       = 3;
  localparam int POINT_W    = COORD_W * AXES;
  localparam int IDX_W      = 10;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int MARGIN_W   = 16;
  localparam int PROD_W     = COORD_W + MARGIN_W;
  // coordinates, then point index, padded to whole bytes
  localparam int IN_DATA_W  = ((POINT_W + IDX_W + 7) / 8) * 8;
  // shifted point, then system size
  localparam int OUT_DATA_W = 2 * POINT_W;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd66;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_INDEX = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXT,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

>>> rtl/pbbn_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
module pbbn_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then read into the registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/point_bounding_box_normalizer.sv
// Add, clear and unused command go from acceptance to the done state, then the output register;
// a valid read first passes through memory read, extent, margin multiply and sum.
// One transaction is in flight at a time: the input is ready again only after the result
// is loaded into the output register, which waits while the output slot is still full.
// Reset (rst, synchronous): count cleared, box to its empty extremes, margin 66;
// point memory contents are kept and need no clearing pass.
module point_bounding_box_normalizer #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration: margin_fraction
  input  logic                             cfg_wr_en,
  input  logic [pbbn_pkg::MARGIN_W-1:0]    cfg_wr_data,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // coord_x, coord_y, coord_z, point_index, zero padding
  input  logic [pbbn_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // cmd
  input  logic [pbbn_pkg::CMD_W-1:0]       s_axis_tuser,
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // shifted_x, shifted_y, shifted_z, size_x, size_y, size_z
  output logic [pbbn_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status
  output logic [pbbn_pkg::STATUS_W-1:0]    m_axis_tuser
);

  import pbbn_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int IW = CW + IDX_W;

  state_t state_q, state_next;

  logic [CW-1:0]             count_q;
  logic [MARGIN_W-1:0]       margin_q;
  logic signed [COORD_W-1:0] low_q  [AXES];
  logic signed [COORD_W-1:0] high_q [AXES];

  status_t             res_status;
  logic [COORD_W-1:0]  res_shift [AXES];
  logic [COORD_W-1:0]  res_size  [AXES];
  logic [COORD_W-1:0]  ext_q     [AXES];
  logic [COORD_W-1:0]  prod_q    [AXES];

  logic                 in_acc;
  logic                 out_load;
  cmd_t                 cmd;
  logic [IDX_W-1:0]     point_index;
  logic [IW-1:0]        idx_ext;
  logic [IW-1:0]        cnt_ext;
  logic                 idx_ok;
  logic                 store_full;
  logic                 ram_we;
  logic                 ram_re;
  logic [POINT_W-1:0]   ram_rdata;
  logic signed [COORD_W-1:0] coord [AXES];

  // decode the input transaction
  always_comb begin
    cmd         = cmd_t'(s_axis_tuser);
    point_index = s_axis_tdata[POINT_W +: IDX_W];
    idx_ext     = IW'(point_index);
    cnt_ext     = IW'(count_q);
    idx_ok      = idx_ext < cnt_ext;
    store_full  = count_q >= CW'(MAX_POINTS);
    for (int a = 0; a < AXES; a++) begin
      coord[a] = s_axis_tdata[COORD_W*a +: COORD_W];
    end
  end

  // next state
  always_comb begin
    state_next = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (cmd == CMD_READ && idx_ok) ? ST_EXT : ST_DONE;
        end
      end
      ST_EXT:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    in_acc        = s_axis_tvalid && s_axis_tready;
    out_load      = (state_q == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
    ram_we        = in_acc && (cmd == CMD_ADD) && !store_full;
    ram_re        = in_acc && (cmd == CMD_READ) && idx_ok;
  end

  pbbn_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_q[AW-1:0]),
    .wdata (s_axis_tdata[POINT_W-1:0]),
    .re    (ram_re),
    .raddr (idx_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  // hold state, count, box and margin
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      margin_q <= MARGIN_RESET;
      for (int a = 0; a < AXES; a++) begin
        low_q[a]  <= COORD_MAX;
        high_q[a] <= COORD_MIN;
      end
    end else begin
      state_q <= state_next;
      if (cfg_wr_en) begin
        margin_q <= cfg_wr_data;
      end
      if (ram_we) begin
        count_q <= count_q + CW'(1);
        for (int a = 0; a < AXES; a++) begin
          if (coord[a] < low_q[a]) begin
            low_q[a] <= coord[a];
          end
          if (coord[a] > high_q[a]) begin
            high_q[a] <= coord[a];
          end
        end
      end else if (in_acc && cmd == CMD_CLEAR) begin
        count_q <= '0;
        for (int a = 0; a < AXES; a++) begin
          low_q[a]  <= COORD_MAX;
          high_q[a] <= COORD_MIN;
        end
      end
    end
  end

  // build the result: status at acceptance, then shift, extent, margin, saturating sum
  always_ff @(posedge clk) begin
    logic [PROD_W-1:0]  prod;
    logic [COORD_W:0]   total;
    if (in_acc) begin
      if (cmd == CMD_ADD && store_full) begin
        res_status <= STATUS_FULL;
      end else if (cmd == CMD_READ && !idx_ok) begin
        res_status <= STATUS_BAD_INDEX;
      end else begin
        res_status <= STATUS_OK;
      end
      for (int a = 0; a < AXES; a++) begin
        res_shift[a] <= '0;
        res_size[a]  <= '0;
      end
    end
    for (int a = 0; a < AXES; a++) begin
      prod  = PROD_W'(ext_q[a]) * PROD_W'(margin_q);
      total = {1'b0, ext_q[a]} + {1'b0, prod_q[a]};
      case (state_q)
        ST_EXT: begin
          res_shift[a] <= ram_rdata[COORD_W*a +: COORD_W] - low_q[a];
          ext_q[a]     <= high_q[a] - low_q[a];
        end
        ST_MUL: begin
          prod_q[a] <= prod[PROD_W-1:MARGIN_W];
        end
        ST_SUM: begin
          res_size[a] <= total[COORD_W] ? '1 : total[COORD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // output register: valid with reset, payload loaded when the slot frees
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser <= res_status;
      for (int a = 0; a < AXES; a++) begin
        m_axis_tdata[COORD_W*a +: COORD_W]           <= res_shift[a];
        m_axis_tdata[POINT_W + COORD_W*a +: COORD_W] <= res_size[a];
      end
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_q <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (count_q < CW'(MAX_POINTS)))
    else $error("point write into a full store");

  a_read_issued: assert property (@(posedge clk) disable iff (rst)
    (state_q == ST_EXT) |-> $past(ram_re))
    else $error("extent step without a memory read");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (count_q == $past(count_q) + CW'(1)))
    else $error("point count did not advance on add");

endmodule

>>> bench/tb_point_bounding_box_normalizer.sv
// Self-checking testbench for the point bounding box normaliser.
`timescale 1ns / 1ps

module tb_point_bounding_box_normalizer;
  import pbbn_pkg::*;

  localparam int MAX_PTS = 1024;

  typedef logic [AXES-1:0][COORD_W-1:0] point_t;

  typedef struct packed {
    status_t                   status;
    logic [AXES-1:0][COORD_W-1:0] shifted;
    logic [AXES-1:0][COORD_W-1:0] sys_size;
  } reply_t;

  // Track the point store and box, predict each reply and compare it.
  class box_tracker;
    logic [MARGIN_W-1:0]      margin;
    point_t                   points [MAX_PTS];
    int unsigned              point_count;
    logic signed [COORD_W-1:0] low [AXES];
    logic signed [COORD_W-1:0] high [AXES];
    reply_t                   pending[$];
    int unsigned              fails;

    function new();
      margin = MARGIN_RESET;
      fails  = 0;
      empty_box();
    endfunction

    function void empty_box();
      point_count = 0;
      for (int a = 0; a < AXES; a++) begin
        low[a]  = COORD_MAX;
        high[a] = COORD_MIN;
      end
    endfunction

    // Extent plus truncated margin, saturated to 32 bits.
    function logic [COORD_W-1:0] padded_extent(logic [COORD_W-1:0] ext);
      logic [PROD_W-1:0]  prod;
      logic [COORD_W:0]   total;
      prod  = {{MARGIN_W{1'b0}}, ext} * {{COORD_W{1'b0}}, margin};
      total = {1'b0, ext} + {1'b0, prod[PROD_W-1:MARGIN_W]};
      return total[COORD_W] ? '1 : total[COORD_W-1:0];
    endfunction

    // Apply one accepted transaction and queue the reply it must produce.
    function void note_command(cmd_t c, point_t pt, logic [IDX_W-1:0] idx);
      reply_t r;
      r = '0;
      r.status = STATUS_OK;
      case (c)
        CMD_ADD: begin
          if (point_count >= MAX_PTS) begin
            r.status = STATUS_FULL;
          end else begin
            points[point_count] = pt;
            point_count++;
            for (int a = 0; a < AXES; a++) begin
              if ($signed(pt[a]) < low[a]) low[a] = pt[a];
              if ($signed(pt[a]) > high[a]) high[a] = pt[a];
            end
          end
        end
        CMD_READ: begin
          if (idx >= point_count) begin
            r.status = STATUS_BAD_INDEX;
          end else begin
            for (int a = 0; a < AXES; a++) begin
              r.shifted[a]  = points[idx][a] - low[a];
              r.sys_size[a] = padded_extent(high[a] - low[a]);
            end
          end
        end
        CMD_CLEAR: empty_box();
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    // Compare one output transaction with the oldest expected reply.
    function void check_reply(logic [STATUS_W-1:0] st, logic [OUT_DATA_W-1:0] data);
      reply_t r;
      string  axis_names;
      logic [COORD_W-1:0] got;
      axis_names = "xyz";
      if (pending.size() == 0) begin
        $error("unexpected result: status %0d data %h", st, data);
        fails++;
        return;
      end
      r = pending.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        fails++;
      end
      for (int a = 0; a < AXES; a++) begin
        got = data[a*COORD_W +: COORD_W];
        if (got !== r.shifted[a]) begin
          $error("shifted_%c: expected %h, got %h", axis_names[a], r.shifted[a], got);
          fails++;
        end
        got = data[POINT_W + a*COORD_W +: COORD_W];
        if (got !== r.sys_size[a]) begin
          $error("size_%c: expected %h, got %h", axis_names[a], r.sys_size[a], got);
          fails++;
        end
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [MARGIN_W-1:0]      cfg_wr_data = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // coord_x, coord_y, coord_z, point_index, zero padding
  logic [IN_DATA_W-1:0]     s_axis_tdata = '0;
  // cmd
  logic [CMD_W-1:0]         s_axis_tuser = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // shifted_x, shifted_y, shifted_z, size_x, size_y, size_z
  logic [OUT_DATA_W-1:0]    m_axis_tdata;
  // status
  logic [STATUS_W-1:0]      m_axis_tuser;

  box_tracker tracker;
  bit         idle_on = 1'b1;
  int         stall_left = 0;

  point_bounding_box_normalizer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result side in random bursts.
  always @(posedge clk) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 12);
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check every output transaction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_reply(m_axis_tuser, m_axis_tdata);
  end

  // Present one command, hold it until the transaction completes, then predict.
  task automatic send_item(cmd_t c, point_t pt, logic [IDX_W-1:0] idx);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {{(IN_DATA_W-POINT_W-IDX_W){1'b0}}, idx, pt};
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_command(c, pt, idx);
  endtask

  // Hold off the input until every expected reply has been taken.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_margin(logic [MARGIN_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.margin = value;
  endtask

  // Mix extremes, full-range values and a narrow band around zero.
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3, 4: return $urandom();
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  task automatic random_item(int add_pct, bit allow_clear);
    int               roll;
    point_t           pt;
    logic [IDX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    pt   = {pick_coord(), pick_coord(), pick_coord()};
    idx  = IDX_W'($urandom());
    if (roll < add_pct) begin
      send_item(CMD_ADD, pt, idx);
    end else if (roll < 95) begin
      if (tracker.point_count != 0 && $urandom_range(0, 99) < 85)
        idx = IDX_W'($urandom_range(0, tracker.point_count - 1));
      send_item(CMD_READ, pt, idx);
    end else if (roll < 98 || !allow_clear) begin
      send_item(CMD_NOP, pt, idx);
    end else begin
      send_item(CMD_CLEAR, pt, idx);
    end
  endtask

  initial begin
    int n;
    bit drained_once;
    tracker = new();
    drained_once = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty reads, unused command, extreme corners, clear, zero extent.
    send_item(CMD_READ, '0, '0);
    send_item(CMD_READ, '0, '1);
    send_item(CMD_NOP, '1, '1);
    send_item(CMD_ADD, {32'd0, COORD_MIN, COORD_MAX}, '0);
    send_item(CMD_READ, '0, '0);
    send_item(CMD_ADD, {32'hFFFF_FFFF, COORD_MAX, COORD_MIN}, '1);
    send_item(CMD_READ, '0, 10'd0);
    send_item(CMD_READ, '0, 10'd1);
    send_item(CMD_READ, '0, 10'd2);
    send_item(CMD_CLEAR, '1, '1);
    send_item(CMD_READ, '0, 10'd0);
    send_item(CMD_ADD, {32'd3, 32'd2, 32'd1}, '0);
    send_item(CMD_READ, '0, 10'd0);
    send_item(CMD_ADD, {32'h0001_0000, -32'sd7, 32'd5}, '0);
    send_item(CMD_READ, '0, 10'd1);
    send_item(CMD_READ, '0, 10'd0);
    send_item(CMD_NOP, '0, '0);
    send_item(CMD_CLEAR, '0, '0);

    // No margin, then the largest margin.
    write_margin('0);
    repeat (60) random_item(55, 1'b1);
    write_margin('1);
    repeat (60) random_item(55, 1'b1);

    // Fill the store to the top with a random margin, then push past it.
    write_margin(MARGIN_W'($urandom()));
    send_item(CMD_CLEAR, '0, '0);
    n = 0;
    while (tracker.point_count < MAX_PTS) begin
      if (n % 50 == 0) idle_on = $urandom_range(0, 2) != 0;
      if (tracker.point_count > 900) idle_on = 1'b0;
      if (!drained_once && tracker.point_count >= MAX_PTS / 2) begin
        wait_drained();
        drained_once = 1'b1;
      end
      random_item(85, 1'b0);
      n++;
    end
    send_item(CMD_READ, '0, '1);
    send_item(CMD_ADD, {pick_coord(), pick_coord(), pick_coord()}, '0);
    repeat (40) random_item(40, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (tracker.fails == 0 && tracker.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Stop a hung run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
rtl/pbbn_pkg.sv
rtl/pbbn_ram.sv
rtl/point_bounding_box_normalizer.sv
bench/tb_point_bounding_box_normalizer.sv
